/* rtl/mcfm_pkg.sv */
`default_nettype none

package mcfm_pkg;

    // Window geometry.
    localparam int WIN_LEN    = 8;
    localparam int CRC_SPAN   = 6;
    localparam int SEEN_W     = 4;
    localparam int CHAIN_LEN  = CRC_SPAN + 1;
    localparam int CHAIN_IDXW = 3;

    // CRC-16/Modbus constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function codes.
    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_WRITE = 8'h06;

    // Largest coil count that a five-bit index can address.
    localparam logic [5:0] MAX_COILS = 6'd32;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COIL_LIMIT     = 1'd1;
    localparam logic [5:0] COIL_LIMIT_RESET = 6'd16;

    typedef struct packed {
        logic [4:0] device_address;
        logic [5:0] coil_limit;
    } cfg_t;

    typedef struct packed {
        logic       frame_found;
        logic       is_write;
        logic [4:0] coil_index;
        logic [7:0] write_value;
    } result_t;

    // One byte of the reflected CRC, eight shift steps.
    function automatic logic [15:0] crc_byte_step(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/mcfm_rx_if.sv */
`default_nettype none

interface mcfm_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/mcfm_res_if.sv */
`default_nettype none

interface mcfm_res_if;
    logic       valid;
    logic       ready;
    logic       frame_found;
    logic       is_write;
    logic [4:0] coil_index;
    logic [7:0] write_value;

    modport source (output valid, output frame_found, output is_write,
                    output coil_index, output write_value, input ready);
    modport sink   (input valid, input frame_found, input is_write,
                    input coil_index, input write_value, output ready);
endinterface

`default_nettype wire

/* rtl/mcfm_crc_chain.sv */
`default_nettype none

// Running CRCs of the runs of one to six bytes ending at the newest. Entry i holds
// the CRC of the last i+1 bytes; the last entry is the six-byte CRC delayed
// by one byte, so on the next byte it covers window bytes zero to five.
module mcfm_crc_chain (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [7:0]  rx_byte,
    output logic      [15:0] frame_crc_next
);

    logic [15:0] crc_reg  [mcfm_pkg::CHAIN_LEN];
    logic [15:0] crc_next [mcfm_pkg::CHAIN_LEN];

    always_comb
    begin
        crc_next[0] = mcfm_pkg::crc_byte_step(mcfm_pkg::CRC_INIT, rx_byte);
        for (int i = 1; i < mcfm_pkg::CRC_SPAN; i++)
        begin
            crc_next[i] = mcfm_pkg::crc_byte_step(crc_reg[i-1], rx_byte);
        end
        crc_next[mcfm_pkg::CRC_SPAN] = crc_reg[mcfm_pkg::CRC_SPAN-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcfm_pkg::CHAIN_LEN; i++)
            begin
                crc_reg[i] <= mcfm_pkg::CRC_INIT;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < mcfm_pkg::CHAIN_LEN; i++)
            begin
                crc_reg[i] <= crc_next[i];
            end
        end
    end

    assign frame_crc_next = crc_reg[mcfm_pkg::CRC_SPAN];

endmodule

`default_nettype wire

/* rtl/mcfm_window.sv */
`default_nettype none

// Eight-byte sliding window, fill count, and the frame check on the window
// as it stands after the incoming byte.
module mcfm_window (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [7:0]                   rx_byte,
    input  wire mcfm_pkg::cfg_t               cfg,
    input  wire logic [15:0]                  frame_crc,
    output mcfm_pkg::result_t                 result_next,
    output logic [mcfm_pkg::SEEN_W-1:0]       seen_count
);

    logic [7:0] window_reg  [mcfm_pkg::WIN_LEN];
    logic [7:0] window_next [mcfm_pkg::WIN_LEN];
    logic [mcfm_pkg::SEEN_W-1:0] seen_reg;
    logic [mcfm_pkg::SEEN_W-1:0] seen_next;
    logic [5:0] limit;
    logic       match;

    always_comb
    begin
        for (int i = 0; i < mcfm_pkg::WIN_LEN - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[mcfm_pkg::WIN_LEN-1] = rx_byte;

        if (seen_reg < mcfm_pkg::SEEN_W'(mcfm_pkg::WIN_LEN))
        begin
            seen_next = seen_reg + 1'b1;
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_comb
    begin
        limit = (cfg.coil_limit > mcfm_pkg::MAX_COILS) ? mcfm_pkg::MAX_COILS
                                                       : cfg.coil_limit;
        match = (seen_next == mcfm_pkg::SEEN_W'(mcfm_pkg::WIN_LEN))
             && (window_next[0] == {3'b000, cfg.device_address})
             && ((window_next[1] == mcfm_pkg::FC_READ)
                 || (window_next[1] == mcfm_pkg::FC_WRITE))
             && (window_next[3] < {2'b00, limit})
             && (window_next[6] == frame_crc[7:0])
             && (window_next[7] == frame_crc[15:8]);

        result_next = '0;
        if (match)
        begin
            result_next.frame_found = 1'b1;
            result_next.is_write    = (window_next[1] == mcfm_pkg::FC_WRITE);
            result_next.coil_index  = window_next[3][4:0];
            result_next.write_value = window_next[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < mcfm_pkg::WIN_LEN; i++)
            begin
                window_reg[i] <= 8'h00;
            end
        end
        else if (load)
        begin
            seen_reg <= seen_next;
            for (int i = 0; i < mcfm_pkg::WIN_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    assign seen_count = seen_reg;

endmodule

`default_nettype wire

/* rtl/modbus_coil_frame_matcher_top.sv */
`default_nettype none

// Channel | Direction | Word contents
// --------+-----------+-----------------------------------------------------
// rx      | in        | rx_byte: one received serial byte
// res     | out       | frame_found, is_write, coil_index, write_value
// cfg     | in        | cfg_we, cfg_index, cfg_data: device_address, coil_limit
//
// Every accepted byte yields exactly one result word, in the cycle after the
// byte is taken; a word can be accepted in every cycle while res.ready is high.
// The result register is the only buffer between the two sides: rx is ready
// whenever that register is empty or its word is being taken in this cycle.
// The CRC of window bytes zero to five is built incrementally by a chain of
// one-byte CRC steps, so no path holds more than one byte of CRC logic.
// Reset clears the window and the fill count, sets the CRC chain to 16'hFFFF and
// sets the registers to device_address 0 and coil_limit 16.
module modbus_coil_frame_matcher_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mcfm_rx_if.sink                                 rx,
    mcfm_res_if.source                              res,
    input  wire logic                               cfg_we,
    input  wire logic [mcfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mcfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mcfm_pkg::cfg_t    cfg_reg;
    mcfm_pkg::result_t result_reg;
    mcfm_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              in_accept;
    logic [15:0]       frame_crc;
    logic [mcfm_pkg::SEEN_W-1:0] seen_count;

    // The input side is free whenever the result register will be empty
    // at the next edge.
    assign rx.ready  = !out_valid_reg || res.ready;
    assign in_accept = rx.valid && rx.ready;

    // Configuration registers; the user must write them only while the block is idle. The block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 5'd0;
            cfg_reg.coil_limit     <= mcfm_pkg::COIL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcfm_pkg::REG_DEVICE_ADDRESS:
                begin
                    cfg_reg.device_address <= cfg_data[4:0];
                end
                mcfm_pkg::REG_COIL_LIMIT:
                begin
                    cfg_reg.coil_limit <= cfg_data[5:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mcfm_crc_chain u_crc_chain (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_accept),
        .rx_byte        (rx.rx_byte),
        .frame_crc_next (frame_crc)
    );

    mcfm_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_accept),
        .rx_byte     (rx.rx_byte),
        .cfg         (cfg_reg),
        .frame_crc   (frame_crc),
        .result_next (result_next),
        .seen_count  (seen_count)
    );

    // Result register with its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.frame_found = result_reg.frame_found;
    assign res.is_write    = result_reg.is_write;
    assign res.coil_index  = result_reg.coil_index;
    assign res.write_value = result_reg.write_value;

    // An accepted byte always leaves a word in the result register.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted byte did not load the result register");

    // A word without a frame carries all-zero fields.
    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.frame_found) |->
        (!result_reg.is_write && result_reg.coil_index == 5'd0
         && result_reg.write_value == 8'h00))
        else $error("result fields set without a frame");

    // A frame can only be reported once the window has filled.
    a_frame_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.frame_found) |->
        (seen_count == mcfm_pkg::SEEN_W'(mcfm_pkg::WIN_LEN)))
        else $error("frame reported before the window filled");

    // The fill count saturates at the window length.
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_count <= mcfm_pkg::SEEN_W'(mcfm_pkg::WIN_LEN))
        else $error("fill count exceeded the window length");

endmodule

`default_nettype wire

/* tb/modbus_coil_frame_matcher_top_test.sv */
module modbus_coil_frame_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random phases. Each phase uses its own register setting.
    localparam int RANDOM_PHASES = 12;
    // Least number of bytes queued in each random phase.
    localparam int PHASE_BYTES = 115;
    // The block answers in the cycle after it takes a byte.
    // The settle wait lets the block go idle after the last word.
    localparam int SETTLE_CYCLES = 3;
    // Only the first few mismatches are printed in full.
    localparam int MAX_REPORTS = 10;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [mcfm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mcfm_pkg::CFG_DATA_W-1:0]  cfg_data;

    mcfm_rx_if  rx_ch ();
    mcfm_res_if res_ch ();

    modbus_coil_frame_matcher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Bytes that wait to be sent, and the result words that the accepted
    // bytes must produce, oldest first.
    logic [7:0]        pending_rx_bytes [$];
    mcfm_pkg::result_t expected_reports [$];

    // The testbench's own copy of the window, the fill count and the
    // registers. The registers start at their reset values.
    logic [7:0] window_copy [0:mcfm_pkg::WIN_LEN-1] = '{default: 8'h00};
    int         window_fill = 0;
    logic [4:0] addr_copy = 5'd0;
    logic [5:0] limit_copy = mcfm_pkg::COIL_LIMIT_RESET;

    // Idling is switched off in some phases and in the last one.
    bit idle_enabled = 1'b1;

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int frames_reported = 0;
    int words_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int send_bursts = 0;
    int recv_bursts = 0;

    // CRC-16/Modbus worked bit by bit, least significant bit of the first
    // byte first. Over whole bytes this gives the same value as the usual
    // byte loop with eight shifts.
    function automatic logic [15:0] crc16_modbus_bits(
        input logic [8*mcfm_pkg::CRC_SPAN-1:0] span);
        logic [15:0] crc;
        logic        feedback;
        int          j;
        crc = mcfm_pkg::CRC_INIT;
        for (j = 0; j < 8 * mcfm_pkg::CRC_SPAN; j++)
        begin
            feedback = crc[0] ^ span[j];
            crc = crc >> 1;
            if (feedback)
            begin
                crc = crc ^ mcfm_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Shifts one byte into the window copy. Returns the result word that
    // the block must produce for this byte.
    function automatic mcfm_pkg::result_t shift_and_match(input logic [7:0] new_byte);
        mcfm_pkg::result_t report;
        logic [5:0]        limit;
        logic [15:0]       crc;
        int                i;
        for (i = 0; i < mcfm_pkg::WIN_LEN - 1; i++)
        begin
            window_copy[i] = window_copy[i + 1];
        end
        window_copy[mcfm_pkg::WIN_LEN - 1] = new_byte;
        if (window_fill < mcfm_pkg::WIN_LEN)
        begin
            window_fill++;
        end

        report = '0;
        if (window_fill >= mcfm_pkg::WIN_LEN)
        begin
            // Limits above thirty-two behave as thirty-two. The coil index
            // must then fit its five bits.
            limit = (limit_copy > mcfm_pkg::MAX_COILS) ? mcfm_pkg::MAX_COILS : limit_copy;
            if (window_copy[0] == {3'b000, addr_copy} &&
                (window_copy[1] == mcfm_pkg::FC_READ ||
                 window_copy[1] == mcfm_pkg::FC_WRITE) &&
                window_copy[3] < {2'b00, limit})
            begin
                crc = crc16_modbus_bits({window_copy[5], window_copy[4], window_copy[3],
                                         window_copy[2], window_copy[1], window_copy[0]});
                if (window_copy[6] == crc[7:0] && window_copy[7] == crc[15:8])
                begin
                    report.frame_found = 1'b1;
                    report.is_write    = (window_copy[1] == mcfm_pkg::FC_WRITE);
                    report.coil_index  = window_copy[3][4:0];
                    report.write_value = window_copy[4];
                end
            end
        end
        return report;
    endfunction

    // Queues one eight-byte request frame with its CRC, low byte first.
    // With corrupt set, one bit anywhere in the frame is flipped. A single
    // flipped bit always breaks the CRC.
    function automatic void queue_frame(input logic [7:0] addr, input logic [7:0] code,
                                        input logic [7:0] coil_hi, input logic [7:0] coil,
                                        input logic [7:0] value, input logic [7:0] spare,
                                        input bit corrupt);
        logic [8*mcfm_pkg::CRC_SPAN-1:0] body;
        logic [15:0]                     crc;
        logic [8*mcfm_pkg::WIN_LEN-1:0]  frame;
        int                              flip;
        int                              k;
        body  = {spare, value, coil, coil_hi, code, addr};
        crc   = crc16_modbus_bits(body);
        frame = {crc[15:8], crc[7:0], body};
        if (corrupt)
        begin
            flip = $urandom_range(0, 8 * mcfm_pkg::WIN_LEN - 1);
            frame[flip] = ~frame[flip];
        end
        for (k = 0; k < mcfm_pkg::WIN_LEN; k++)
        begin
            pending_rx_bytes.push_back(frame[8 * k +: 8]);
        end
        bytes_queued += mcfm_pkg::WIN_LEN;
    endfunction

    // Fills one phase. Most items are well-formed frames with random
    // content. Some frames are corrupted, and short runs of line noise fall
    // between frames. Noise can also shift a frame against the window.
    function automatic void fill_random_phase(input int n_bytes);
        int         start;
        int         pick;
        int         noise_len;
        int         k;
        logic [7:0] addr;
        logic [7:0] code;
        logic [7:0] coil;
        logic [7:0] value;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                // Addresses above thirty-one can never match.
                addr  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : {3'b000, addr_copy};
                if ($urandom_range(0, 9) == 0)
                begin
                    code = 8'($urandom_range(0, 255));
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    code = mcfm_pkg::FC_WRITE;
                end
                else
                begin
                    code = mcfm_pkg::FC_READ;
                end
                coil  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 35));
                // Write values other than on, off and toggle are still reported.
                value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(1, 3));
                queue_frame(addr, code, 8'($urandom_range(0, 255)), coil, value,
                            8'($urandom_range(0, 255)), pick >= 65);
            end
            else
            begin
                noise_len = $urandom_range(1, 6);
                for (k = 0; k < noise_len; k++)
                begin
                    pending_rx_bytes.push_back(8'($urandom_range(0, 255)));
                end
                bytes_queued += noise_len;
            end
        end
    endfunction

    // Register writes happen only while no byte is in flight. The copy is
    // updated at the same time, so the next byte sees the new setting.
    task automatic write_register(input logic [mcfm_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [mcfm_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == mcfm_pkg::REG_DEVICE_ADDRESS)
        begin
            addr_copy = value[4:0];
        end
        else
        begin
            limit_copy = value;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued byte has been taken and every result word
    // has come. Then lets the block settle.
    task automatic wait_until_idle();
        @(posedge clk);
        while (bytes_accepted != bytes_queued || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte driver. A byte stays on the bus until the block takes it. Each
    // accepted byte is run through the predictor at once. Between bytes the
    // driver may go quiet for a burst of cycles. valid and rx_byte get one
    // nonblocking assignment per edge, so a back-to-back byte keeps valid
    // high without a glitch.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic       next_valid;
        logic [7:0] next_byte;
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'h00;
        end
        else
        begin
            next_valid = rx_ch.valid;
            next_byte  = rx_ch.rx_byte;
            if (rx_ch.valid && rx_ch.ready)
            begin
                expected_reports.push_back(shift_and_match(rx_ch.rx_byte));
                bytes_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_rx_bytes.size() != 0)
                begin
                    if (idle_enabled && $urandom_range(0, 4) == 0)
                    begin
                        send_gap = $urandom_range(1, 15) - 1;
                        send_bursts++;
                    end
                    else
                    begin
                        next_valid = 1'b1;
                        next_byte  = pending_rx_bytes.pop_front();
                    end
                end
            end
            rx_ch.valid   <= next_valid;
            rx_ch.rx_byte <= next_byte;
        end
    end

    // Result monitor. It takes each result word and checks it field by
    // field against the oldest expected word. A word that comes with
    // nothing expected is also a failure. ready drops in random bursts while idling is on.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        mcfm_pkg::result_t want;
        logic              next_ready;
        bit                bad;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                words_checked++;
                if (res_ch.frame_found === 1'b1)
                begin
                    frames_reported++;
                end
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: word %0d unexpected: found=%b write=%b coil=%0d value=%0h",
                                 words_checked, res_ch.frame_found, res_ch.is_write,
                                 res_ch.coil_index, res_ch.write_value);
                    end
                end
                else
                begin
                    want = expected_reports.pop_front();
                    bad  = (res_ch.frame_found !== want.frame_found) ||
                           (res_ch.is_write    !== want.is_write)    ||
                           (res_ch.coil_index  !== want.coil_index)  ||
                           (res_ch.write_value !== want.write_value);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("ERROR: word %0d want found=%b write=%b coil=%0d value=%0h",
                                     words_checked, want.frame_found, want.is_write,
                                     want.coil_index, want.write_value);
                            $display("       got  found=%b write=%b coil=%0d value=%0h",
                                     res_ch.frame_found, res_ch.is_write,
                                     res_ch.coil_index, res_ch.write_value);
                        end
                    end
                end
            end

            if (recv_stall > 0)
            begin
                recv_stall--;
                next_ready = 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(1, 15) - 1;
                recv_bursts++;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            res_ch.ready <= next_ready;
        end
    end

    // Main sequence: reset, a short directed part with the reset register
    // values, then random phases. Each random phase starts from a new
    // register setting. Every phase ends with the sender held back until
    // every expected word has come. That drain is also the only safe point
    // for a register write.
    initial
    begin : stimulus
        int         p;
        logic [5:0] addr_data;
        logic [5:0] limit_data;

        // The channel signals are cleared by the driver and the monitor
        // while reset is asserted.
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = mcfm_pkg::REG_DEVICE_ADDRESS;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with address 0 and limit 16 from reset. In the
        // first frame, the first seven bytes come before a full window and
        // must report nothing. The frame completes at the eighth byte: a
        // read of the highest legal coil, with a value outside on, off and
        // toggle. Next comes a write with the extreme byte values. Last
        // comes a frame whose coil index equals the limit and is rejected.
        queue_frame(8'h00, mcfm_pkg::FC_READ, 8'h00, 8'd15, 8'h00, 8'h00, 1'b0);
        queue_frame(8'h00, mcfm_pkg::FC_WRITE, 8'hFF, 8'd0, 8'hFF, 8'hFF, 1'b0);
        queue_frame(8'h00, mcfm_pkg::FC_WRITE, 8'h00, 8'd16, 8'd1, 8'h00, 1'b0);
        wait_until_idle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            // The first phases cover the extreme settings. These include
            // address data with its unused top bit set, a limit of zero
            // and limits above thirty-two.
            case (p)
                0:
                begin
                    addr_data  = 6'd31;
                    limit_data = 6'd32;
                end
                1:
                begin
                    addr_data  = 6'd37;
                    limit_data = 6'd63;
                end
                2:
                begin
                    addr_data  = 6'd0;
                    limit_data = 6'd0;
                end
                3:
                begin
                    addr_data  = 6'd21;
                    limit_data = 6'd33;
                end
                4:
                begin
                    addr_data  = 6'd10;
                    limit_data = 6'd16;
                end
                5:
                begin
                    addr_data  = 6'd1;
                    limit_data = 6'd31;
                end
                default:
                begin
                    addr_data  = 6'($urandom_range(0, 63));
                    limit_data = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                             : 6'($urandom_range(16, 32));
                end
            endcase
            write_register(mcfm_pkg::REG_DEVICE_ADDRESS, addr_data);
            write_register(mcfm_pkg::REG_COIL_LIMIT, limit_data);
            settings_used++;

            // Some stretches run without idling. The last phase never idles.
            idle_enabled = !(p == 3 || p == 7 || p == RANDOM_PHASES - 1);
            fill_random_phase(PHASE_BYTES);
            wait_until_idle();
        end

        $display("Run summary: %0d bytes taken under %0d register settings, %0d frames.",
                 bytes_accepted, settings_used + 1, frames_reported);
        $display("Idle bursts: %0d on the byte side, %0d on the result side.",
                 send_bursts, recv_bursts);
        if (mismatch_count == 0 && expected_reports.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog. The slowest correct run is far below this limit, even
    // with the longest gaps and stalls on every byte.
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout: the run did not complete.");
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/mcfm_pkg.sv
rtl/mcfm_rx_if.sv
rtl/mcfm_res_if.sv
rtl/mcfm_crc_chain.sv
rtl/mcfm_window.sv
rtl/modbus_coil_frame_matcher_top.sv
tb/modbus_coil_frame_matcher_top_test.sv
